// ===== hw/rtl/spc_pkg.sv =====
// Package with the shared constants, types and arithmetic constants of the sweep pulse classifier.
`default_nettype none

package spc_pkg;

  localparam int NUM_SENSORS = 4;
  localparam int STAMP_BITS  = 16;

  localparam int SENSOR_W = 2;
  localparam int STAMP_W  = 16;
  localparam int ANGLE_W  = 15;
  localparam int IDX_W    = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

  localparam logic [STAMP_W-1:0] STAMP_MASK =
    (STAMP_BITS >= STAMP_W) ? {STAMP_W{1'b1}} : STAMP_W'((64'd1 << STAMP_BITS) - 64'd1);

  localparam logic [STAMP_W-1:0] LIMIT_RESET = 16'd416;

  // The sync quotient (576 * len - 275100) / 50000 is reduced by four and
  // evaluated as a multiply by an exact reciprocal of 12500.
  localparam logic signed [24:0] SYNC_OFFSET = 25'sd68775;
  localparam logic [24:0]        SYNC_RECIP  = 25'd21990233;
  localparam int                 SYNC_SHIFT  = 38;

  // The angle 135 * (start + end) / 1000 is reduced to 27 * sum / 200, with
  // an exact reciprocal of 200.
  localparam logic [22:0] ANG_RECIP = 23'd5368710;
  localparam int          ANG_SHIFT = 30;

  localparam logic [ANGLE_W-1:0] ANGLE_OFFSET = 15'd9000;
  localparam logic [ANGLE_W-1:0] ANGLE_RESET  = 15'h5CD8;

  typedef enum logic [1:0] {
    KIND_BASE_SYNC  = 2'd0,
    KIND_CYCLE_SYNC = 2'd1,
    KIND_SWEEP_X    = 2'd2,
    KIND_SWEEP_Y    = 2'd3
  } pulse_kind_t;

  typedef struct packed {
    pulse_kind_t        kind;
    logic [2:0]         sync_bits;
    logic [ANGLE_W-1:0] angle;
  } pulse_info_t;

  typedef struct packed {
    logic [SENSOR_W-1:0] sensor_id;
    pulse_kind_t         kind;
    logic                axis_bit;
    logic                data_bit;
    logic                skip_bit;
    logic [ANGLE_W-1:0]  x_angle;
    logic [ANGLE_W-1:0]  y_angle;
    logic                pair_ready;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sweep_pulse_classifier.sv =====
// Top level of the sweep pulse classifier: input stage, result register and register port.
`default_nettype none

// Each request is one optical pulse (sensor, start and end counts) and yields
// one result carrying the pulse kind and that sensor's flags and angles after
// the pulse. A request is registered, decoded by one pass of logic and written
// into the result register once that register is free, and one request is
// taken every clock while the result register is not stalled. The input
// stage can take one request while a result waits, holding it until the
// result register frees up. The sweep length limit may be written at any idle
// time and resets to 416 counts.

module sweep_pulse_classifier (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,  // start_count[15:0], end_count[31:16]
  input  wire logic [1:0]  in_tuser,  // sensor_index[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // axis_bit[0], data_bit[1], skip_bit[2], x_angle[17:3], y_angle[32:18],
  // pair_ready[33], zero[39:34]
  output logic [39:0]      out_tdata,
  output logic [3:0]       out_tuser, // sensor_id[1:0], pulse_kind[3:2]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  logic                         s1_valid_r;
  logic                         s1_valid_nxt;
  logic [spc_pkg::SENSOR_W-1:0] s1_sensor_r;
  logic [spc_pkg::STAMP_W-1:0]  s1_start_r;
  logic [spc_pkg::STAMP_W-1:0]  s1_end_r;
  logic                         out_valid_r;
  logic                         out_valid_nxt;
  spc_pkg::result_t             out_r;
  logic [spc_pkg::STAMP_W-1:0]  limit_r;
  logic                         advance;
  logic                         in_take;
  spc_pkg::pulse_info_t         info;
  spc_pkg::result_t             result;

  spc_pulse_math u_math (
    .start_count (s1_start_r),
    .end_count   (s1_end_r),
    .limit       (limit_r),
    .info        (info)
  );

  spc_sensor_state u_state (
    .clk    (clk),
    .rst_n  (rst_n),
    .commit (advance),
    .sensor (s1_sensor_r),
    .info   (info),
    .result (result)
  );

  always_comb begin
    advance   = s1_valid_r && (!out_valid_r || out_tready);
    in_tready = !s1_valid_r || advance;
    in_take   = in_tvalid && in_tready;
    cfg_ready = 1'b1;

    s1_valid_nxt = in_take ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end

    out_tvalid = out_valid_r;
    out_tuser  = {out_r.kind, out_r.sensor_id};
    out_tdata  = {6'd0, out_r.pair_ready, out_r.y_angle, out_r.x_angle,
                  out_r.skip_bit, out_r.data_bit, out_r.axis_bit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      limit_r     <= spc_pkg::LIMIT_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_sensor_r <= in_tuser;
      s1_start_r  <= in_tdata[15:0];
      s1_end_r    <= in_tdata[31:16];
    end
    if (advance) begin
      out_r <= result;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/spc_pulse_math.sv =====
// Pulse classification, sync bit decode and sweep angle arithmetic.
`default_nettype none

module spc_pulse_math (
  input  wire logic [spc_pkg::STAMP_W-1:0] start_count,
  input  wire logic [spc_pkg::STAMP_W-1:0] end_count,
  input  wire logic [spc_pkg::STAMP_W-1:0] limit,
  output spc_pkg::pulse_info_t             info
);

  logic [spc_pkg::STAMP_W-1:0] s_m;
  logic [spc_pkg::STAMP_W-1:0] e_m;
  logic signed [16:0]          len;
  logic signed [17:0]          len_w;
  logic signed [17:0]          lim_w;
  logic signed [24:0]          len_x;
  logic signed [24:0]          sync_num;
  logic                        sync_pos;
  logic [48:0]                 sync_prod;
  logic [16:0]                 sum;
  logic [21:0]                 ang_num;
  logic [44:0]                 ang_prod;
  logic [spc_pkg::ANGLE_W-1:0] ang_q;

  always_comb begin
    s_m   = start_count & spc_pkg::STAMP_MASK;
    e_m   = end_count & spc_pkg::STAMP_MASK;
    len   = $signed({1'b0, e_m}) - $signed({1'b0, s_m});
    len_w = {len[16], len};
    lim_w = $signed({2'b00, limit});

    len_x     = {{8{len[16]}}, len};
    sync_num  = (len_x <<< 7) + (len_x <<< 4) - spc_pkg::SYNC_OFFSET;
    sync_pos  = !sync_num[24] && (sync_num != 25'sd0);
    sync_prod = sync_num[23:0] * spc_pkg::SYNC_RECIP;

    sum      = {1'b0, s_m} + {1'b0, e_m};
    ang_num  = ({5'd0, sum} << 4) + ({5'd0, sum} << 3) + ({5'd0, sum} << 1) + {5'd0, sum};
    ang_prod = ang_num * spc_pkg::ANG_RECIP;
    ang_q    = ang_prod[spc_pkg::ANG_SHIFT +: spc_pkg::ANGLE_W];

    info.sync_bits = sync_pos ? sync_prod[spc_pkg::SYNC_SHIFT +: 3] : 3'd0;
    info.angle     = ang_q - spc_pkg::ANGLE_OFFSET;

    if (s_m == '0) begin
      info.kind = spc_pkg::KIND_BASE_SYNC;
    end else if (len_w > lim_w) begin
      info.kind = spc_pkg::KIND_CYCLE_SYNC;
    end else begin
      info.kind = spc_pkg::KIND_SWEEP_X;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/spc_sensor_state.sv =====
// Per-sensor flag and angle registers with their update and the result readout.
`default_nettype none

module spc_sensor_state (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         commit,
  input  wire logic [spc_pkg::SENSOR_W-1:0] sensor,
  input  wire spc_pkg::pulse_info_t         info,
  output spc_pkg::result_t                  result
);

  localparam int IW = spc_pkg::IDX_W;

  logic                        axis_r [spc_pkg::NUM_SENSORS];
  logic                        data_r [spc_pkg::NUM_SENSORS];
  logic                        skip_r [spc_pkg::NUM_SENSORS];
  logic [spc_pkg::ANGLE_W-1:0] x_r    [spc_pkg::NUM_SENSORS];
  logic [spc_pkg::ANGLE_W-1:0] y_r    [spc_pkg::NUM_SENSORS];

  logic                        valid;
  logic [IW-1:0]               sel;
  logic                        axis_cur;
  logic                        data_cur;
  logic                        skip_cur;
  logic [spc_pkg::ANGLE_W-1:0] x_cur;
  logic [spc_pkg::ANGLE_W-1:0] y_cur;
  logic                        axis_new;
  logic                        data_new;
  logic                        skip_new;
  logic [spc_pkg::ANGLE_W-1:0] x_new;
  logic [spc_pkg::ANGLE_W-1:0] y_new;
  logic                        pair_new;
  spc_pkg::pulse_kind_t        kind_new;

  always_comb begin
    valid    = 32'(sensor) < 32'(spc_pkg::NUM_SENSORS);
    sel      = IW'(sensor);
    axis_cur = 1'b0;
    data_cur = 1'b0;
    skip_cur = 1'b0;
    x_cur    = '0;
    y_cur    = '0;
    if (valid) begin
      axis_cur = axis_r[sel];
      data_cur = data_r[sel];
      skip_cur = skip_r[sel];
      x_cur    = x_r[sel];
      y_cur    = y_r[sel];
    end

    axis_new = axis_cur;
    data_new = data_cur;
    skip_new = skip_cur;
    x_new    = x_cur;
    y_new    = y_cur;
    pair_new = 1'b0;
    kind_new = info.kind;
    case (info.kind)
      spc_pkg::KIND_BASE_SYNC: begin
        axis_new = info.sync_bits[0];
        data_new = info.sync_bits[1];
        skip_new = info.sync_bits[2];
      end
      spc_pkg::KIND_CYCLE_SYNC: begin
        axis_new = info.sync_bits[0];
      end
      default: begin
        if (axis_cur) begin
          kind_new = spc_pkg::KIND_SWEEP_Y;
          y_new    = info.angle;
          pair_new = 1'b1;
        end else begin
          kind_new = spc_pkg::KIND_SWEEP_X;
          x_new    = info.angle;
        end
      end
    endcase

    result.sensor_id  = sensor;
    result.kind       = kind_new;
    result.axis_bit   = valid & axis_new;
    result.data_bit   = valid & data_new;
    result.skip_bit   = valid & skip_new;
    result.x_angle    = valid ? x_new : '0;
    result.y_angle    = valid ? y_new : '0;
    result.pair_ready = valid & pair_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < spc_pkg::NUM_SENSORS; i++) begin
        axis_r[i] <= 1'b0;
        data_r[i] <= 1'b0;
        skip_r[i] <= 1'b0;
        x_r[i]    <= spc_pkg::ANGLE_RESET;
        y_r[i]    <= spc_pkg::ANGLE_RESET;
      end
    end else if (commit && valid) begin
      axis_r[sel] <= axis_new;
      data_r[sel] <= data_new;
      skip_r[sel] <= skip_new;
      x_r[sel]    <= x_new;
      y_r[sel]    <= y_new;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/spc_checker.sv =====
// Port-level checker for the sweep pulse classifier and its bind to the top level.
`default_nettype none

module spc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata,
  input wire logic [3:0]  out_tuser
);

  // A stalled result holds its contents.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // A result only appears for a request that was taken and passed through the input register and the result register.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result without a matching request");

  // With no result pending the input side never stalls.
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while result register empty");

  // A completed pair is only flagged on a Y sweep.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[33] |-> out_tuser[3:2] == spc_pkg::KIND_SWEEP_Y)
    else $error("pair flagged on a non-Y pulse");

endmodule

bind sweep_pulse_classifier spc_checker u_spc_checker (.*);

`default_nettype wire

// ===== bench/spc_checker.sv =====
// Checker that predicts each pulse result of the sweep pulse classifier and compares it with the output.
`timescale 1ns / 1ps

module spc_bench_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [31:0] in_tdata,
  input  wire logic [1:0]  in_tuser,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [39:0] out_tdata,
  input  wire logic [3:0]  out_tuser,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [15:0] cfg_data,
  output int               mismatch_count,
  output int               results_pending
);

  localparam int ANGLE_AT_RESET = -9000;
  localparam int AW             = spc_pkg::ANGLE_W;

  logic [15:0]       length_limit;
  logic              axis_q [spc_pkg::NUM_SENSORS];
  logic              data_q [spc_pkg::NUM_SENSORS];
  logic              skip_q [spc_pkg::NUM_SENSORS];
  logic [AW-1:0]     x_deg [spc_pkg::NUM_SENSORS];
  logic [AW-1:0]     y_deg [spc_pkg::NUM_SENSORS];
  spc_pkg::result_t  expected_results [$];
  spc_pkg::result_t  want;
  int                fails;

  function automatic int sync_code(int len);
    int num;
    num = len * 576 - 275100;
    return (num <= 0) ? 0 : num / 50000;
  endfunction

  // Updates the per-sensor flags and angles for one pulse and returns the result it yields.
  function automatic spc_pkg::result_t classify_pulse(logic [1:0] sensor,
                                                      logic [15:0] start_raw,
                                                      logic [15:0] stop_raw);
    int               s;
    int               e;
    int               len;
    int               code;
    int               idx;
    bit               known;
    logic [AW-1:0]    ang;
    spc_pkg::result_t r;
    s = int'(start_raw & spc_pkg::STAMP_MASK);
    e = int'(stop_raw & spc_pkg::STAMP_MASK);
    len = e - s;
    idx = int'(sensor);
    known = idx < spc_pkg::NUM_SENSORS;
    r = '0;
    r.sensor_id = sensor;
    if (s == 0) begin
      r.kind = spc_pkg::KIND_BASE_SYNC;
      code = sync_code(len);
      if (known) begin
        axis_q[idx] = code[0];
        data_q[idx] = code[1];
        skip_q[idx] = code[2];
      end
    end else if (len > int'(length_limit)) begin
      r.kind = spc_pkg::KIND_CYCLE_SYNC;
      code = sync_code(len);
      if (known) axis_q[idx] = code[0];
    end else begin
      ang = AW'((s + e) * 135 / 1000 - 9000);
      if (known && axis_q[idx]) begin
        r.kind = spc_pkg::KIND_SWEEP_Y;
        y_deg[idx] = ang;
        r.pair_ready = 1'b1;
      end else begin
        r.kind = spc_pkg::KIND_SWEEP_X;
        if (known) x_deg[idx] = ang;
      end
    end
    if (known) begin
      r.axis_bit = axis_q[idx];
      r.data_bit = data_q[idx];
      r.skip_bit = skip_q[idx];
      r.x_angle  = x_deg[idx];
      r.y_angle  = y_deg[idx];
    end
    return r;
  endfunction

  task automatic compare_field(string name, logic [31:0] expected_val, logic [31:0] actual_val);
    if (expected_val !== actual_val) begin
      fails++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, expected_val,
               actual_val);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      length_limit = spc_pkg::LIMIT_RESET;
      for (int i = 0; i < spc_pkg::NUM_SENSORS; i++) begin
        axis_q[i] = 1'b0;
        data_q[i] = 1'b0;
        skip_q[i] = 1'b0;
        x_deg[i]  = AW'(ANGLE_AT_RESET);
        y_deg[i]  = AW'(ANGLE_AT_RESET);
      end
      expected_results.delete();
      fails = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          fails++;
          $display("%0t: result with no request pending, expected none, actual tuser %h tdata %h",
                   $time, out_tuser, out_tdata);
        end else begin
          want = expected_results.pop_front();
          compare_field("sensor_id", want.sensor_id, out_tuser[1:0]);
          compare_field("pulse_kind", want.kind, out_tuser[3:2]);
          compare_field("axis_bit", want.axis_bit, out_tdata[0]);
          compare_field("data_bit", want.data_bit, out_tdata[1]);
          compare_field("skip_bit", want.skip_bit, out_tdata[2]);
          compare_field("x_angle", want.x_angle, out_tdata[17:3]);
          compare_field("y_angle", want.y_angle, out_tdata[32:18]);
          compare_field("pair_ready", want.pair_ready, out_tdata[33]);
          compare_field("tdata padding", 0, out_tdata[39:34]);
        end
      end
      if (cfg_valid && cfg_ready) length_limit = cfg_data;
      if (in_tvalid && in_tready)
        expected_results.push_back(classify_pulse(in_tuser, in_tdata[15:0], in_tdata[31:16]));
    end
    mismatch_count  <= fails;
    results_pending <= expected_results.size();
  end

endmodule

// ===== bench/sweep_pulse_classifier_tb.sv =====
// Testbench top for the sweep pulse classifier: clock, reset, pulse stimulus and final verdict.
`timescale 1ns / 1ps

module sweep_pulse_classifier_tb;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic [3:0]  out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;
  int          mismatch_count;
  int          results_pending;
  int          quiet_cycles;
  int          limit_now;
  bit          tx_calm;
  bit          rx_calm;
  bit          hold_request;

  sweep_pulse_classifier dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  spc_bench_checker pulse_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .results_pending(results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  task automatic send_pulse(logic [1:0] sensor, logic [15:0] start_cnt, logic [15:0] stop_cnt);
    if (!tx_calm && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap_len()) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {stop_cnt, start_cnt};
    in_tuser  <= sensor;
    do @(posedge clk); while (!in_tready);
  endtask

  // Mostly well-formed sync and sweep pulses for the current limit, with some raw noise.
  task automatic send_random_pulse();
    int pick;
    int len;
    int s;
    int e;
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      s = 0;
      e = ($urandom_range(0, 2) != 0) ? $urandom_range(400, 1500) : $urandom_range(0, 65535);
    end else if (pick < 4 && limit_now < 65000) begin
      len = $urandom_range(limit_now + 1, (limit_now + 3000 > 65534) ? 65534 : limit_now + 3000);
      s = $urandom_range(1, 65535 - len);
      e = s + len;
    end else if (pick < 9) begin
      len = $urandom_range(0, (limit_now > 65534) ? 65534 : limit_now);
      s = $urandom_range(1, 65535 - len);
      e = s + len;
    end else begin
      s = $urandom_range(0, 65535);
      e = $urandom_range(0, 65535);
    end
    send_pulse(2'($urandom_range(0, 3)), 16'(s), 16'(e));
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= 16'(value);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    out_tready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (!rx_calm && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat (gap_len()) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    quiet_cycles = 0;
    tx_calm      = 1'b0;
    rx_calm      = 1'b0;
    hold_request = 1'b0;
    limit_now    = 416;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed pulses against the limit left by reset.
    send_pulse(2'd0, 16'd0, 16'd0);
    send_pulse(2'd1, 16'd1, 16'd1);
    send_pulse(2'd2, 16'hFFFF, 16'hFFFF);
    send_pulse(2'd3, 16'hFFFF, 16'd0);
    send_pulse(2'd0, 16'd0, 16'd600);
    send_pulse(2'd0, 16'd1, 16'd417);
    send_pulse(2'd0, 16'd100, 16'd517);
    send_pulse(2'd0, 16'd200, 16'd300);
    send_pulse(2'd1, 16'd0, 16'd760);
    send_pulse(2'd1, 16'd0, 16'd1100);
    send_pulse(2'd1, 16'd5000, 16'd5300);
    send_pulse(2'd2, 16'd0, 16'hFFFF);
    send_pulse(2'd2, 16'd1000, 16'd1600);
    send_pulse(2'd2, 16'd40000, 16'd40100);
    send_pulse(2'd3, 16'd0, 16'd478);
    send_pulse(2'd3, 16'd0, 16'd5000);
    send_pulse(2'd3, 16'd32768, 16'd32768);
    send_pulse(2'd1, 16'd1, 16'hFFFF);
    send_pulse(2'd2, 16'h5555, 16'hAAAA);
    send_pulse(2'd0, 16'hAAAA, 16'h5555);

    for (int phase = 0; phase < 5; phase++) begin
      drain();
      case (phase)
        0:       limit_now = 0;
        1:       limit_now = 65535;
        2:       limit_now = 416;
        3:       limit_now = 1000;
        default: limit_now = $urandom_range(0, 65535);
      endcase
      write_limit(limit_now);
      tx_calm = (phase == 1) || ($urandom_range(0, 3) == 0);
      rx_calm = (phase != 1) && ($urandom_range(0, 3) == 0);
      if (phase == 1) hold_request = 1'b1;
      repeat (100) send_random_pulse();
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
